// ===== src/j9s_pkg.sv =====
// ----------------------------------------------------------------------------
// j9s_pkg: shared definitions of the nine-point stencil stream unit
// Widths, defaults, register indexes, result slot codes and the coefficient
// table used by the column cells, the result queue and the top level.
// ----------------------------------------------------------------------------
package j9s_pkg;

    localparam int unsigned MAX_WIDTH_DEF   = 1024;
    localparam int unsigned SAMPLE_BITS_DEF = 32;

    // result queue: entries, and the most results one sample can cause
    localparam int unsigned QUEUE_DEPTH = 16;
    localparam int unsigned MAX_RESULTS = 4;

    localparam int unsigned ROW_BITS       = 16;
    localparam int unsigned COL_BITS       = 10;
    localparam int unsigned WIDTH_REG_BITS = 11;
    localparam int unsigned CFG_IDX_BITS   = 2;
    localparam int unsigned CFG_DATA_BITS  = 16;

    localparam logic [WIDTH_REG_BITS-1:0] WIDTH_RESET  = 11'd22;
    localparam logic [ROW_BITS-1:0]       HEIGHT_RESET = 16'd22;

    // configuration register indexes
    localparam logic [CFG_IDX_BITS-1:0] REG_FRAME_WIDTH  = 2'd0;
    localparam logic [CFG_IDX_BITS-1:0] REG_FRAME_HEIGHT = 2'd1;

    // result slots of one sample, in emission order
    localparam logic [1:0] SLOT_CENTER   = 2'd0; // cell up-left of the sample
    localparam logic [1:0] SLOT_EDGE     = 2'd1; // last column, row above
    localparam logic [1:0] SLOT_LAST_ROW = 2'd2; // last row, left of the sample
    localparam logic [1:0] SLOT_CORNER   = 2'd3; // last row, last column

    // Q0.16 coefficients, [row above/same/below][column left/center/right]
    localparam int unsigned COEF_BITS  = 16;
    localparam int unsigned FRAC_BITS  = 16;
    localparam int          ROUND_HALF = 32768;
    localparam logic signed [COEF_BITS-1:0] COEF_TAB [3][3] = '{
        '{-16'sd4588, -16'sd3932, -16'sd3277},
        '{-16'sd5243,  16'sd23593, -16'sd2621},
        '{-16'sd655,  -16'sd1311, -16'sd1966}
    };

    // bookkeeping of the results that one sample causes
    typedef struct packed {
        logic [3:0]          emit;     // one bit per result slot
        logic [ROW_BITS-1:0] row_prev; // row above the sample
        logic [ROW_BITS-1:0] row_cur;  // row of the sample
        logic [COL_BITS-1:0] col_prev; // column left of the sample
        logic [COL_BITS-1:0] col_last; // last column of the frame
    } emit_meta_t;

endpackage

// ===== src/j9s_cell.sv =====
// ----------------------------------------------------------------------------
// j9s_cell: one window column of the stencil
// Holds three samples of a column, hands them to the next cell on each shift
// and forms the weighted column sum in two register stages.
// ----------------------------------------------------------------------------
module j9s_cell
    import j9s_pkg::*;
#(
    parameter int unsigned SAMPLE_BITS = SAMPLE_BITS_DEF,
    parameter int unsigned COL         = 0
) (
    input  logic                               aclk,
    input  logic                               shift_en,
    input  logic [2:0][SAMPLE_BITS-1:0]        col_in,
    output logic [2:0][SAMPLE_BITS-1:0]        col_out,
    output logic signed [SAMPLE_BITS+17:0]     psum_out
);

    localparam int unsigned PRW = SAMPLE_BITS + COEF_BITS;
    localparam int unsigned PSW = SAMPLE_BITS + 18;

    logic [2:0][SAMPLE_BITS-1:0] col_reg;
    logic [2:0][SAMPLE_BITS-1:0] col_next;
    logic signed [PRW-1:0]       prod_reg  [3];
    logic signed [PRW-1:0]       prod_next [3];
    logic signed [PSW-1:0]       psum_reg;
    logic signed [PSW-1:0]       psum_next;

    always_comb begin
        col_next = shift_en ? col_in : col_reg;
        for (int k = 0; k < 3; k++) begin
            prod_next[k] = PRW'($signed(col_reg[k])) * PRW'(COEF_TAB[k][COL]);
        end
        psum_next = PSW'(prod_reg[0]) + PSW'(prod_reg[1]) + PSW'(prod_reg[2]);
    end

    always_ff @(posedge aclk) begin
        col_reg  <= col_next;
        prod_reg <= prod_next;
        psum_reg <= psum_next;
    end

    assign col_out  = col_reg;
    assign psum_out = psum_reg;

endmodule

// ===== src/j9s_out_queue.sv =====
// ----------------------------------------------------------------------------
// j9s_out_queue: result queue of the stencil stream unit
// Stores one entry per sample with results and sends its results one per
// transaction, lowest slot first.
// ----------------------------------------------------------------------------
module j9s_out_queue
    import j9s_pkg::*;
#(
    parameter int unsigned SAMPLE_BITS = SAMPLE_BITS_DEF,
    parameter int unsigned DEPTH       = QUEUE_DEPTH,
    localparam int unsigned TDW = ((SAMPLE_BITS + ROW_BITS + COL_BITS + 7) / 8) * 8
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          push_en,
    input  emit_meta_t                    push_meta,
    input  logic [3:0][SAMPLE_BITS-1:0]   push_vals,
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [TDW-1:0]                m_tdata, // value, row, col, zero pad
    output logic                          m_tlast,
    output logic                          m_tuser  // frame_last
);

    localparam int unsigned AW = $clog2(DEPTH);
    localparam int unsigned NW = $clog2(DEPTH + 1);

    emit_meta_t                  meta_mem [DEPTH];
    logic [3:0][SAMPLE_BITS-1:0] vals_mem [DEPTH];

    logic [AW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [AW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [NW-1:0] count_reg, count_next;
    logic [3:0]    sent_reg, sent_next;

    emit_meta_t                  head_meta;
    logic [3:0][SAMPLE_BITS-1:0] head_vals;
    logic [3:0]                  remaining;
    logic [3:0]                  sel_mask;
    logic [1:0]                  sel_idx;
    logic                        run_last;
    logic                        m_hs;
    logic                        pop;
    logic [SAMPLE_BITS-1:0]      out_value;
    logic [ROW_BITS-1:0]         out_row;
    logic [COL_BITS-1:0]         out_col;

    assign head_meta = meta_mem[rd_ptr_reg];
    assign head_vals = vals_mem[rd_ptr_reg];
    assign remaining = head_meta.emit & ~sent_reg;

    always_comb begin
        priority if (remaining[SLOT_CENTER]) begin
            sel_idx = SLOT_CENTER;
        end else if (remaining[SLOT_EDGE]) begin
            sel_idx = SLOT_EDGE;
        end else if (remaining[SLOT_LAST_ROW]) begin
            sel_idx = SLOT_LAST_ROW;
        end else begin
            sel_idx = SLOT_CORNER;
        end
    end

    assign sel_mask = 4'b0001 << sel_idx;
    assign run_last = (remaining & ~sel_mask) == 4'b0000;

    always_comb begin
        out_value = head_vals[sel_idx];
        unique case (sel_idx)
            SLOT_CENTER: begin
                out_row = head_meta.row_prev;
                out_col = head_meta.col_prev;
            end
            SLOT_EDGE: begin
                out_row = head_meta.row_prev;
                out_col = head_meta.col_last;
            end
            SLOT_LAST_ROW: begin
                out_row = head_meta.row_cur;
                out_col = head_meta.col_prev;
            end
            default: begin
                out_row = head_meta.row_cur;
                out_col = head_meta.col_last;
            end
        endcase
    end

    assign m_tvalid = count_reg != '0;
    assign m_tdata  = TDW'({out_col, out_row, out_value});
    assign m_tlast  = run_last;
    assign m_tuser  = sel_idx == SLOT_CORNER;

    assign m_hs = m_tvalid && m_tready;
    assign pop  = m_hs && run_last;

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        sent_next   = sent_reg;
        if (push_en) begin
            wr_ptr_next = (wr_ptr_reg == AW'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop) begin
            rd_ptr_next = (rd_ptr_reg == AW'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            sent_next   = 4'b0000;
        end else if (m_hs) begin
            sent_next = sent_reg | sel_mask;
        end
        count_next = count_reg + NW'(push_en) - NW'(pop);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
            sent_reg   <= 4'b0000;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
            sent_reg   <= sent_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push_en) begin
            meta_mem[wr_ptr_reg] <= push_meta;
            vals_mem[wr_ptr_reg] <= push_vals;
        end
    end

endmodule

// ===== src/jacobi_9pt_stencil_stream_unit.sv =====
// ----------------------------------------------------------------------------
// jacobi_9pt_stencil_stream_unit: streaming nine-point weighted stencil
// Path: a sample's results pass the pipeline stages, then the result queue.
// Throughput: one sample per cycle while s_tready is high; results leave one
// per cycle while m_tready is high, so row-end result bursts can drop s_tready.
// Reset: clears frame counters, pipeline valid bits and the result queue, sets
// the default frame size; the line stores are uncleared and need no clearing.
// ----------------------------------------------------------------------------
module jacobi_9pt_stencil_stream_unit
    import j9s_pkg::*;
#(
    parameter int unsigned MAX_WIDTH   = MAX_WIDTH_DEF,
    parameter int unsigned SAMPLE_BITS = SAMPLE_BITS_DEF,
    localparam int unsigned S_TDW = ((SAMPLE_BITS + 7) / 8) * 8,
    localparam int unsigned M_TDW = ((SAMPLE_BITS + ROW_BITS + COL_BITS + 7) / 8) * 8
) (
    input  logic                     aclk,
    input  logic                     aresetn,
    // sample stream
    input  logic                     s_tvalid,
    output logic                     s_tready,
    input  logic [S_TDW-1:0]         s_tdata,   // sample, zero pad
    // result stream
    output logic                     m_tvalid,
    input  logic                     m_tready,
    output logic [M_TDW-1:0]         m_tdata,   // value, row, col, zero pad
    output logic                     m_tlast,   // run_last
    output logic                     m_tuser,   // frame_last
    // configuration writes
    input  logic                     cfg_valid,
    output logic                     cfg_ready,
    input  logic [CFG_IDX_BITS-1:0]  cfg_index,
    input  logic [CFG_DATA_BITS-1:0] cfg_data
);

    localparam int unsigned SB   = SAMPLE_BITS;
    localparam int unsigned CW   = $clog2(MAX_WIDTH);
    localparam int unsigned CXW  = (CW > COL_BITS) ? CW : COL_BITS;
    localparam int unsigned WEW  = ($clog2(MAX_WIDTH + 1) > WIDTH_REG_BITS) ?
                                   $clog2(MAX_WIDTH + 1) : WIDTH_REG_BITS;
    localparam int unsigned PSW  = SB + 18;
    localparam int unsigned SUMW = SB + 20;
    localparam int unsigned RW   = SB + 4;
    localparam int unsigned PNW  = $clog2(QUEUE_DEPTH + 1);

    // ------------------------------------------------------------------
    // Configuration: a write to either register restarts the frame at
    // row 0, column 0; a write to any other index changes nothing.
    // ------------------------------------------------------------------
    logic [WIDTH_REG_BITS-1:0] frame_width_reg, frame_width_next;
    logic [ROW_BITS-1:0]       frame_height_reg, frame_height_next;
    logic                      cfg_hs;
    logic                      cfg_restart;

    assign cfg_ready   = 1'b1;
    assign cfg_hs      = cfg_valid && cfg_ready;
    assign cfg_restart = cfg_hs && ((cfg_index == REG_FRAME_WIDTH) ||
                                    (cfg_index == REG_FRAME_HEIGHT));

    always_comb begin
        frame_width_next  = frame_width_reg;
        frame_height_next = frame_height_reg;
        if (cfg_hs) begin
            unique case (cfg_index)
                REG_FRAME_WIDTH:  frame_width_next  = cfg_data[WIDTH_REG_BITS-1:0];
                REG_FRAME_HEIGHT: frame_height_next = cfg_data;
                default: begin
                    frame_width_next  = frame_width_reg;
                    frame_height_next = frame_height_reg;
                end
            endcase
        end
    end

    // Clamp the frame size: width to [3, MAX_WIDTH], height to at least 3.
    logic [WEW-1:0]      fw_ext;
    logic [WEW-1:0]      width_eff;
    logic [CW-1:0]       width_last;
    logic [ROW_BITS-1:0] height_last;

    always_comb begin
        fw_ext = WEW'(frame_width_reg);
        if (fw_ext < WEW'(3)) begin
            width_eff = WEW'(3);
        end else if (fw_ext > WEW'(MAX_WIDTH)) begin
            width_eff = WEW'(MAX_WIDTH);
        end else begin
            width_eff = fw_ext;
        end
        width_last  = CW'(width_eff - WEW'(1));
        height_last = (frame_height_reg < ROW_BITS'(3)) ? ROW_BITS'(2) :
                      frame_height_reg - 1'b1;
    end

    // ------------------------------------------------------------------
    // Stage 0: take the sample, step the frame position, work out which
    // results it causes and reserve queue room for them.
    // ------------------------------------------------------------------
    logic [CW-1:0]       col_count_reg, col_count_next;
    logic [ROW_BITS-1:0] row_count_reg, row_count_next;
    logic [SB-1:0]       s_sample;
    logic                s_hs;
    logic                m_hs;
    logic                row_above, col_left, at_last_col, at_last_row, inner0;
    logic [3:0]          emit0;
    logic [2:0]          emit_cnt;
    emit_meta_t          meta0;
    logic [CXW-1:0]      col_prev_x, col_last_x;
    logic [PNW-1:0]      pending_reg, pending_next;

    assign s_sample = s_tdata[SB-1:0];
    assign s_hs     = s_tvalid && s_tready;
    assign m_hs     = m_tvalid && m_tready;

    // room for a full burst of results must stay free in the queue
    assign s_tready = pending_reg <= PNW'(QUEUE_DEPTH - MAX_RESULTS);

    always_comb begin
        row_above   = row_count_reg != '0;
        col_left    = col_count_reg != '0;
        at_last_col = col_count_reg == width_last;
        at_last_row = row_count_reg == height_last;
        inner0      = (row_count_reg >= ROW_BITS'(2)) && (col_count_reg >= CW'(2));

        emit0[SLOT_CENTER]   = row_above && col_left;
        emit0[SLOT_EDGE]     = row_above && at_last_col;
        emit0[SLOT_LAST_ROW] = row_above && at_last_row && col_left;
        emit0[SLOT_CORNER]   = row_above && at_last_row && at_last_col;
        emit_cnt = 3'(emit0[0]) + 3'(emit0[1]) + 3'(emit0[2]) + 3'(emit0[3]);

        col_prev_x     = CXW'(col_count_reg - 1'b1);
        col_last_x     = CXW'(width_last);
        meta0.emit     = emit0;
        meta0.row_prev = row_count_reg - 1'b1;
        meta0.row_cur  = row_count_reg;
        meta0.col_prev = col_prev_x[COL_BITS-1:0];
        meta0.col_last = col_last_x[COL_BITS-1:0];
    end

    always_comb begin
        col_count_next = col_count_reg;
        row_count_next = row_count_reg;
        if (cfg_restart) begin
            col_count_next = '0;
            row_count_next = '0;
        end else if (s_hs) begin
            if (col_count_reg >= width_last) begin
                col_count_next = '0;
                row_count_next = (row_count_reg >= height_last) ? '0 :
                                 row_count_reg + 1'b1;
            end else begin
                col_count_next = col_count_reg + 1'b1;
            end
        end
        pending_next = pending_reg + (s_hs ? PNW'(emit_cnt) : '0) - PNW'(m_hs);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            frame_width_reg  <= WIDTH_RESET;
            frame_height_reg <= HEIGHT_RESET;
            col_count_reg    <= '0;
            row_count_reg    <= '0;
            pending_reg      <= '0;
        end else begin
            frame_width_reg  <= frame_width_next;
            frame_height_reg <= frame_height_next;
            col_count_reg    <= col_count_next;
            row_count_reg    <= row_count_next;
            pending_reg      <= pending_next;
        end
    end

    // ------------------------------------------------------------------
    // Line stores. Read both at the sample's column in stage 0; the middle
    // store takes the sample there at once, the upper store takes the old
    // middle entry in stage 1, well before that column comes back.
    // ------------------------------------------------------------------
    logic [SB-1:0] upper_mem  [MAX_WIDTH];
    logic [SB-1:0] middle_mem [MAX_WIDTH];
    logic [SB-1:0] upper_rd_reg;
    logic [SB-1:0] middle_rd_reg;

    // stage 1 registers
    logic          v1_reg;
    logic [SB-1:0] s1_reg;
    logic [CW-1:0] c1_reg;
    emit_meta_t    meta1_reg;
    logic          inner1_reg;

    always_ff @(posedge aclk) begin
        if (s_hs) begin
            upper_rd_reg <= upper_mem[col_count_reg];
        end
        if (v1_reg) begin
            upper_mem[c1_reg] <= middle_rd_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_hs) begin
            middle_rd_reg              <= middle_mem[col_count_reg];
            middle_mem[col_count_reg]  <= s_sample;
        end
    end

    // ------------------------------------------------------------------
    // Stage 1: shift the window. The newest column enters the right cell
    // and each cell hands its column to the cell on its left.
    // ------------------------------------------------------------------
    logic [2:0][SB-1:0]    col_new;
    logic [2:0][SB-1:0]    col_w0, col_w1, col_w2;
    logic signed [PSW-1:0] psum0, psum1, psum2;

    assign col_new = {s1_reg, middle_rd_reg, upper_rd_reg};

    j9s_cell #(.SAMPLE_BITS(SB), .COL(2)) u_cell_right (
        .aclk     (aclk),
        .shift_en (v1_reg),
        .col_in   (col_new),
        .col_out  (col_w2),
        .psum_out (psum2)
    );

    j9s_cell #(.SAMPLE_BITS(SB), .COL(1)) u_cell_center (
        .aclk     (aclk),
        .shift_en (v1_reg),
        .col_in   (col_w2),
        .col_out  (col_w1),
        .psum_out (psum1)
    );

    j9s_cell #(.SAMPLE_BITS(SB), .COL(0)) u_cell_left (
        .aclk     (aclk),
        .shift_en (v1_reg),
        .col_in   (col_w1),
        .col_out  (col_w0),
        .psum_out (psum0)
    );

    // ------------------------------------------------------------------
    // Stages 2 to 5: the cells form products and column sums; capture the
    // copied border values beside them, add the columns, round, saturate.
    // ------------------------------------------------------------------
    logic               v2_reg, v3_reg, v4_reg, v5_reg;
    emit_meta_t         meta2_reg, meta3_reg, meta4_reg, meta5_reg;
    logic               inner2_reg, inner3_reg, inner4_reg, inner5_reg;
    logic [3:0][SB-1:0] border2;
    logic [3:0][SB-1:0] border3_reg, border4_reg, border5_reg;
    logic signed [SUMW-1:0] total_next, total_reg;

    // col_w0 only feeds the left cell's products
    assign border2[SLOT_CENTER]   = col_w1[1];
    assign border2[SLOT_EDGE]     = col_w2[1];
    assign border2[SLOT_LAST_ROW] = col_w1[2];
    assign border2[SLOT_CORNER]   = col_w2[2];

    assign total_next = SUMW'(psum0) + SUMW'(psum1) + SUMW'(psum2) + SUMW'(ROUND_HALF);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
            v5_reg <= 1'b0;
        end else begin
            v1_reg <= s_hs;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
            v4_reg <= v3_reg;
            v5_reg <= v4_reg;
        end
    end

    always_ff @(posedge aclk) begin
        s1_reg      <= s_sample;
        c1_reg      <= col_count_reg;
        meta1_reg   <= meta0;
        inner1_reg  <= inner0;
        meta2_reg   <= meta1_reg;
        inner2_reg  <= inner1_reg;
        meta3_reg   <= meta2_reg;
        inner3_reg  <= inner2_reg;
        border3_reg <= border2;
        meta4_reg   <= meta3_reg;
        inner4_reg  <= inner3_reg;
        border4_reg <= border3_reg;
        meta5_reg   <= meta4_reg;
        inner5_reg  <= inner4_reg;
        border5_reg <= border4_reg;
        total_reg   <= total_next;
    end

    // floor shift gives round to nearest, ties upward; clamp to SB bits
    logic signed [RW-1:0] rnd_q;
    logic                 in_range;
    logic [SB-1:0]        sat_val;
    logic [3:0][SB-1:0]   result_vals;
    logic                 push_en;

    always_comb begin
        rnd_q    = total_reg[SUMW-1:FRAC_BITS];
        in_range = (&rnd_q[RW-1:SB-1]) || !(|rnd_q[RW-1:SB-1]);
        if (in_range) begin
            sat_val = rnd_q[SB-1:0];
        end else if (rnd_q[RW-1]) begin
            sat_val = {1'b1, {(SB-1){1'b0}}};
        end else begin
            sat_val = {1'b0, {(SB-1){1'b1}}};
        end
        result_vals = border5_reg;
        if (inner5_reg) begin
            result_vals[SLOT_CENTER] = sat_val;
        end
    end

    // samples that cause no result leave the pipeline here
    assign push_en = v5_reg && (meta5_reg.emit != 4'b0000);

    j9s_out_queue #(.SAMPLE_BITS(SB), .DEPTH(QUEUE_DEPTH)) u_out_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push_en   (push_en),
        .push_meta (meta5_reg),
        .push_vals (result_vals),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .m_tuser   (m_tuser)
    );

`ifndef SYNTH
    a_pending_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        pending_reg <= PNW'(QUEUE_DEPTH))
        else $error("result reservations exceed queue depth");

    a_push_reserved: assert property (@(posedge aclk) disable iff (!aresetn)
        push_en |-> pending_reg != '0)
        else $error("queue entry pushed without reserved room");

    a_out_reserved: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> pending_reg != '0)
        else $error("result offered with no reservation outstanding");

    a_col_in_frame: assert property (@(posedge aclk) disable iff (!aresetn)
        col_count_reg <= width_last)
        else $error("column counter ran past the last column");

    a_frame_last_ends_run: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tuser) |-> m_tlast)
        else $error("final cell of frame is not the last result of its sample");
`endif

endmodule
